>>> rtl/core/mdfs_pkg.sv
// Shared types and constants of the maze depth-first explorer.
package mdfs_pkg;

   localparam int GRID_SIDE_DEFAULT = 256;
   localparam int MAX_DEPTH_DEFAULT = 65536;
   localparam int EPOCH_W           = 8;

   localparam logic [7:0] START_X_RESET = 8'd128;
   localparam logic [7:0] START_Y_RESET = 8'd128;

   // register select, taken from paddr[2]
   localparam logic CSR_START_X = 1'b0;
   localparam logic CSR_START_Y = 1'b1;

   localparam logic [2:0] REQ_ASK      = 3'd0;
   localparam logic [2:0] REQ_UP       = 3'd1;
   localparam logic [2:0] REQ_DOWN     = 3'd2;
   localparam logic [2:0] REQ_LEFT     = 3'd3;
   localparam logic [2:0] REQ_RIGHT    = 3'd4;
   localparam logic [2:0] REQ_PATH     = 3'd5;
   localparam logic [2:0] REQ_FOUND    = 3'd6;
   localparam logic [2:0] REQ_NOTFOUND = 3'd7;

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ASK,
      PH_TRY,
      PH_UNDO,
      PH_REPORT,
      PH_FOUND,
      PH_NOTFOUND
   } phase_type;

   typedef struct packed {
      logic fire;
      logic start;
      logic ans;
   } step_ctrl_type;

   typedef struct packed {
      logic [2:0] req;
      logic [1:0] dir;
      logic       last;
   } result_type;

endpackage

>>> rtl/core/mdfs_visit_map.sv
// Visited map: epoch-tagged cell memory with a clearing sweep on reset and epoch wrap.
module mdfs_visit_map #(
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic              visited,
   input  logic              begin_search,
   input  logic              mark_en,
   input  logic [ADDR_W-1:0] mark_addr,
   output logic              busy
);

   logic [mdfs_pkg::EPOCH_W-1:0] map_mem [2**ADDR_W];
   logic [mdfs_pkg::EPOCH_W-1:0] rd_data_ff;

   logic [mdfs_pkg::EPOCH_W-1:0] epoch_ff, epoch_in;
   logic                         clearing_ff, clearing_in;
   logic [ADDR_W-1:0]            sweep_ff, sweep_in;
   logic                         pend_ff, pend_in;
   logic [ADDR_W-1:0]            pend_addr_ff, pend_addr_in;

   logic                         wrap;
   logic                         sweep_end;
   logic                         wr_en;
   logic [ADDR_W-1:0]            wr_addr;
   logic [mdfs_pkg::EPOCH_W-1:0] wr_data;

   assign wrap      = (epoch_ff == '1);
   assign sweep_end = clearing_ff && (sweep_ff == '1);
   assign visited   = (rd_data_ff == epoch_ff);
   assign busy      = clearing_ff || pend_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = mark_addr;
      wr_data = epoch_ff;
      if (clearing_ff) begin
         wr_en   = 1'b1;
         wr_addr = sweep_ff;
         wr_data = '0;
      end else if (pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff;
      end else if (mark_en && !(begin_search && wrap)) begin
         wr_en   = 1'b1;
         wr_data = begin_search ? epoch_ff + 1'b1 : epoch_ff;
      end
   end

   always_comb begin
      epoch_in     = epoch_ff;
      clearing_in  = clearing_ff;
      sweep_in     = clearing_ff ? sweep_ff + 1'b1 : '0;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      if (sweep_end) begin
         clearing_in = 1'b0;
         // a wrap-triggered sweep restarts at the first live epoch
         epoch_in    = wrap ? mdfs_pkg::EPOCH_W'(1) : epoch_ff;
      end else if (!clearing_ff && pend_ff) begin
         pend_in = 1'b0;
      end else if (begin_search) begin
         if (wrap) begin
            clearing_in  = 1'b1;
            pend_in      = mark_en;
            pend_addr_in = mark_addr;
         end else begin
            epoch_in = epoch_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff    <= '0;
         clearing_ff <= 1'b1;
         sweep_ff    <= '0;
         pend_ff     <= 1'b0;
      end else begin
         epoch_ff    <= epoch_in;
         clearing_ff <= clearing_in;
         sweep_ff    <= sweep_in;
         pend_ff     <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
   end

endmodule

>>> rtl/core/mdfs_stack_mem.sv
// Direction stack: one write and one registered read port.
module mdfs_stack_mem #(
   parameter int DEPTH  = 65536,
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [1:0]        rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [1:0]        wr_data
);

   logic [1:0] stack_mem [DEPTH];
   logic [1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

endmodule

>>> rtl/core/mdfs_search.sv
// Search sequencer: position, depth and phase, and the decision for each word.
module mdfs_search #(
   parameter int GRID_SIDE = mdfs_pkg::GRID_SIDE_DEFAULT,
   parameter int MAX_DEPTH = mdfs_pkg::MAX_DEPTH_DEFAULT,
   localparam int CW  = $clog2(GRID_SIDE),
   localparam int MW  = 2 * CW,
   localparam int DW  = $clog2(MAX_DEPTH + 1),
   localparam int SAW = $clog2(MAX_DEPTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mdfs_pkg::step_ctrl_type ctrl,
   input  logic [7:0]             start_x,
   input  logic [7:0]             start_y,
   output logic [MW-1:0]          map_rd_addr,
   input  logic                   map_visited,
   output logic                   map_begin,
   output logic                   map_mark_en,
   output logic [MW-1:0]          map_mark_addr,
   output logic [SAW-1:0]         stk_rd_addr,
   input  logic [1:0]             stk_rd_data,
   output logic                   stk_wr_en,
   output logic [SAW-1:0]         stk_wr_addr,
   output logic [1:0]             stk_wr_data,
   output mdfs_pkg::result_type   result
);

   mdfs_pkg::phase_type phase_ff, phase_in;
   logic [1:0]          dir_ff, dir_in;
   logic [CW-1:0]       pos_x_ff, pos_x_in;
   logic [CW-1:0]       pos_y_ff, pos_y_in;
   logic [DW-1:0]       depth_ff, depth_in;
   logic [DW-1:0]       rindex_ff, rindex_in;

   logic [CW:0]   nx, ny;
   logic [CW-1:0] bx, by;
   logic [DW-1:0] depth_m1;
   logic          off_grid, blocked, depth_zero, fin, start_ok;
   logic [2:0]    adv_d;
   logic          do_adv, adv_back;

   always_comb begin
      nx = {1'b0, pos_x_ff};
      ny = {1'b0, pos_y_ff};
      case (dir_ff)
         mdfs_pkg::DIR_UP:    ny = {1'b0, pos_y_ff} + (CW + 1)'(1);
         mdfs_pkg::DIR_DOWN:  ny = {1'b0, pos_y_ff} - (CW + 1)'(1);
         mdfs_pkg::DIR_LEFT:  nx = {1'b0, pos_x_ff} - (CW + 1)'(1);
         default:             nx = {1'b0, pos_x_ff} + (CW + 1)'(1);
      endcase
   end

   // backtrack undoes the popped direction
   always_comb begin
      bx = pos_x_ff;
      by = pos_y_ff;
      case (stk_rd_data)
         mdfs_pkg::DIR_UP:    by = pos_y_ff - 1'b1;
         mdfs_pkg::DIR_DOWN:  by = pos_y_ff + 1'b1;
         mdfs_pkg::DIR_LEFT:  bx = pos_x_ff + 1'b1;
         default:             bx = pos_x_ff - 1'b1;
      endcase
   end

   assign depth_m1    = depth_ff - 1'b1;
   assign off_grid    = (nx >= (CW + 1)'(GRID_SIDE)) || (ny >= (CW + 1)'(GRID_SIDE));
   assign blocked     = off_grid || map_visited || (depth_ff == DW'(MAX_DEPTH));
   assign depth_zero  = (depth_ff == '0);
   assign fin         = (rindex_ff + 1'b1) >= depth_ff;
   assign start_ok    = (32'(start_x) < GRID_SIDE) && (32'(start_y) < GRID_SIDE);
   assign map_rd_addr = {ny[CW-1:0], nx[CW-1:0]};
   assign stk_rd_addr = (phase_ff == mdfs_pkg::PH_REPORT) ? rindex_ff[SAW-1:0]
                                                          : depth_m1[SAW-1:0];
   assign stk_wr_addr = depth_ff[SAW-1:0];
   assign stk_wr_data = dir_ff;

   assign adv_d    = (phase_ff == mdfs_pkg::PH_ASK) ? 3'd0 : {1'b0, dir_ff} + 3'd1;
   assign do_adv   = ((phase_ff == mdfs_pkg::PH_ASK) && !ctrl.ans) ||
                     ((phase_ff == mdfs_pkg::PH_TRY) && !ctrl.ans) ||
                     (phase_ff == mdfs_pkg::PH_UNDO);
   assign adv_back = adv_d[2];

   // next state
   always_comb begin
      phase_in  = phase_ff;
      dir_in    = dir_ff;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      depth_in  = depth_ff;
      rindex_in = rindex_ff;
      if (ctrl.fire) begin
         if (ctrl.start) begin
            depth_in  = '0;
            rindex_in = '0;
            pos_x_in  = CW'(start_x);
            pos_y_in  = CW'(start_y);
            phase_in  = start_ok ? mdfs_pkg::PH_ASK : mdfs_pkg::PH_NOTFOUND;
         end else begin
            case (phase_ff)
               mdfs_pkg::PH_ASK: begin
                  if (ctrl.ans) begin
                     rindex_in = '0;
                     phase_in  = depth_zero ? mdfs_pkg::PH_FOUND : mdfs_pkg::PH_REPORT;
                  end
               end
               mdfs_pkg::PH_TRY: begin
                  if (ctrl.ans) begin
                     if (blocked) begin
                        phase_in = mdfs_pkg::PH_UNDO;
                     end else begin
                        pos_x_in = nx[CW-1:0];
                        pos_y_in = ny[CW-1:0];
                        depth_in = depth_ff + 1'b1;
                        phase_in = mdfs_pkg::PH_ASK;
                     end
                  end
               end
               mdfs_pkg::PH_REPORT: begin
                  rindex_in = rindex_ff + 1'b1;
                  if (fin) begin
                     phase_in = mdfs_pkg::PH_FOUND;
                  end
               end
               default: ;
            endcase
            if (do_adv) begin
               if (!adv_back) begin
                  phase_in = mdfs_pkg::PH_TRY;
                  dir_in   = adv_d[1:0];
               end else if (depth_zero) begin
                  phase_in = mdfs_pkg::PH_NOTFOUND;
               end else begin
                  depth_in = depth_m1;
                  pos_x_in = bx;
                  pos_y_in = by;
                  phase_in = mdfs_pkg::PH_UNDO;
                  dir_in   = stk_rd_data;
               end
            end
         end
      end
   end

   // outputs
   always_comb begin
      result        = '{req: mdfs_pkg::REQ_NOTFOUND, dir: 2'd0, last: 1'b1};
      map_begin     = 1'b0;
      map_mark_en   = 1'b0;
      map_mark_addr = map_rd_addr;
      stk_wr_en     = 1'b0;
      if (ctrl.fire) begin
         if (ctrl.start) begin
            map_begin     = 1'b1;
            map_mark_en   = start_ok;
            map_mark_addr = {CW'(start_y), CW'(start_x)};
            if (start_ok) begin
               result = '{req: mdfs_pkg::REQ_ASK, dir: 2'd0, last: 1'b0};
            end
         end else begin
            case (phase_ff)
               mdfs_pkg::PH_ASK: begin
                  if (ctrl.ans) begin
                     result = '{req: mdfs_pkg::REQ_FOUND, dir: 2'd0, last: depth_zero};
                  end
               end
               mdfs_pkg::PH_TRY: begin
                  if (ctrl.ans) begin
                     if (blocked) begin
                        result = '{req: {1'b0, dir_ff ^ 2'b01} + mdfs_pkg::REQ_UP,
                                   dir: 2'd0, last: 1'b0};
                     end else begin
                        map_mark_en = 1'b1;
                        stk_wr_en   = 1'b1;
                        result = '{req: mdfs_pkg::REQ_ASK, dir: 2'd0, last: 1'b0};
                     end
                  end
               end
               mdfs_pkg::PH_REPORT: begin
                  result = '{req: mdfs_pkg::REQ_PATH, dir: stk_rd_data, last: fin};
               end
               mdfs_pkg::PH_FOUND: begin
                  result = '{req: mdfs_pkg::REQ_FOUND, dir: 2'd0, last: 1'b1};
               end
               default: ;
            endcase
            if (do_adv) begin
               if (!adv_back) begin
                  result = '{req: {1'b0, adv_d[1:0]} + mdfs_pkg::REQ_UP,
                             dir: 2'd0, last: 1'b0};
               end else if (depth_zero) begin
                  result = '{req: mdfs_pkg::REQ_NOTFOUND, dir: 2'd0, last: 1'b1};
               end else begin
                  result = '{req: {1'b0, stk_rd_data ^ 2'b01} + mdfs_pkg::REQ_UP,
                             dir: 2'd0, last: 1'b0};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= mdfs_pkg::PH_IDLE;
         dir_ff    <= mdfs_pkg::DIR_UP;
         pos_x_ff  <= CW'(mdfs_pkg::START_X_RESET);
         pos_y_ff  <= CW'(mdfs_pkg::START_Y_RESET);
         depth_ff  <= '0;
         rindex_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         dir_ff    <= dir_in;
         pos_x_ff  <= pos_x_in;
         pos_y_ff  <= pos_y_in;
         depth_ff  <= depth_in;
         rindex_ff <= rindex_in;
      end
   end

endmodule

>>> rtl/core/maze_dfs_explorer.sv
// Top level: maze depth-first explorer with stream ports and register port.
// Accepted words are registered in busy_ff, start_ff and ans_ff, then their result in rsp_valid_ff
// and rsp_data_ff once the output is free; no new word is taken before then (map and stack write).
// Reset: synchronous; the visited map sweep clears all 4**clog2(GRID_SIDE) cells (65536 by default)
// with req_tready low; the same sweep runs after every 2**EPOCH_W-1 searches, on a start.
module maze_dfs_explorer #(
   parameter int GRID_SIDE = mdfs_pkg::GRID_SIDE_DEFAULT,
   parameter int MAX_DEPTH = mdfs_pkg::MAX_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [0] answer, [7:1] zero
   input  logic        req_tuser,    // [0] start_req
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [2:0] request, [4:3] path_direction, [7:5] zero
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW  = $clog2(GRID_SIDE);
   localparam int MW  = 2 * CW;
   localparam int SAW = $clog2(MAX_DEPTH);

   logic [7:0] start_x_ff, start_x_in;
   logic [7:0] start_y_ff, start_y_in;
   logic       busy_ff, busy_in;
   logic       start_ff, start_in;
   logic       ans_ff, ans_in;
   logic       rsp_valid_ff, rsp_valid_in;
   mdfs_pkg::result_type rsp_data_ff, rsp_data_in;

   logic                    accept, fire, csr_wr;
   mdfs_pkg::step_ctrl_type ctrl;
   mdfs_pkg::result_type    result;
   logic                    map_busy, map_visited, map_begin, map_mark_en;
   logic [MW-1:0]           map_rd_addr, map_mark_addr;
   logic [SAW-1:0]          stk_rd_addr, stk_wr_addr;
   logic [1:0]              stk_rd_data, stk_wr_data;
   logic                    stk_wr_en;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = {24'd0, (csr_paddr[2] == mdfs_pkg::CSR_START_Y) ? start_y_ff
                                                                        : start_x_ff};

   // map and stack are read at accept and written at fire; gating ready keeps them apart
   assign req_tready = !busy_ff && !map_busy;
   assign accept     = req_tvalid && req_tready;
   assign fire       = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign ctrl       = '{fire: fire, start: start_ff, ans: ans_ff};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff.dir, rsp_data_ff.req};
   assign rsp_tlast  = rsp_data_ff.last;

   always_comb begin
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == mdfs_pkg::CSR_START_Y) begin
            start_y_in = csr_pwdata[7:0];
         end else begin
            start_x_in = csr_pwdata[7:0];
         end
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      start_in     = start_ff;
      ans_in       = ans_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         busy_in  = 1'b1;
         start_in = req_tuser;
         ans_in   = req_tdata[0];
      end
      if (fire) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff   <= mdfs_pkg::START_X_RESET;
         start_y_ff   <= mdfs_pkg::START_Y_RESET;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      ans_ff      <= ans_in;
      rsp_data_ff <= rsp_data_in;
   end

   mdfs_search #(
      .GRID_SIDE (GRID_SIDE),
      .MAX_DEPTH (MAX_DEPTH)
   ) u_search (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .start_x       (start_x_ff),
      .start_y       (start_y_ff),
      .map_rd_addr   (map_rd_addr),
      .map_visited   (map_visited),
      .map_begin     (map_begin),
      .map_mark_en   (map_mark_en),
      .map_mark_addr (map_mark_addr),
      .stk_rd_addr   (stk_rd_addr),
      .stk_rd_data   (stk_rd_data),
      .stk_wr_en     (stk_wr_en),
      .stk_wr_addr   (stk_wr_addr),
      .stk_wr_data   (stk_wr_data),
      .result        (result)
   );

   mdfs_visit_map #(
      .ADDR_W (MW)
   ) u_visit_map (
      .clock        (clock),
      .reset        (reset),
      .rd_en        (accept),
      .rd_addr      (map_rd_addr),
      .visited      (map_visited),
      .begin_search (map_begin),
      .mark_en      (map_mark_en),
      .mark_addr    (map_mark_addr),
      .busy         (map_busy)
   );

   mdfs_stack_mem #(
      .DEPTH  (MAX_DEPTH),
      .ADDR_W (SAW)
   ) u_stack_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data)
   );

   a_fire_delivers: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !rsp_valid_ff |=> rsp_valid_ff && !busy_ff)
      else $error("pending word not delivered to output register");

   a_notfound_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.req == mdfs_pkg::REQ_NOTFOUND) |-> rsp_data_ff.last)
      else $error("not found word without last");

   a_dir_only_path: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.req != mdfs_pkg::REQ_PATH) |-> (rsp_data_ff.dir == 2'd0))
      else $error("direction set on a word that is not a path step");

endmodule

>>> tb/maze_dfs_checker.sv
// Checker for the maze explorer: predicts each response word and compares it.
module maze_dfs_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,    // [0] answer, [7:1] zero
   input  logic        req_tuser,    // [0] start_req
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,    // [2:0] request, [4:3] path_direction, [7:5] zero
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   input  logic        end_of_test,
   output int          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIDE      = mdfs_pkg::GRID_SIDE_DEFAULT;
   localparam int DEPTH_CAP = mdfs_pkg::MAX_DEPTH_DEFAULT;
   localparam logic [1:0] NO_DIR = 2'b00;

   logic [7:0]           start_x_q;
   logic [7:0]           start_y_q;
   bit                   visited [int];
   logic [1:0]           path_stack [DEPTH_CAP];
   int                   stack_depth;
   int                   pos_x;
   int                   pos_y;
   int                   report_idx;
   mdfs_pkg::phase_type  phase;
   logic [1:0]           phase_dir;
   mdfs_pkg::result_type pending_requests [$];
   mdfs_pkg::result_type want;
   logic [7:0]           reg_value;
   bit                   leftovers_done;

   function automatic int step_dx(logic [1:0] d);
      return d == mdfs_pkg::DIR_LEFT ? -1 : (d == mdfs_pkg::DIR_RIGHT ? 1 : 0);
   endfunction

   function automatic int step_dy(logic [1:0] d);
      return d == mdfs_pkg::DIR_UP ? 1 : (d == mdfs_pkg::DIR_DOWN ? -1 : 0);
   endfunction

   function automatic logic [2:0] move_request(logic [1:0] d);
      return mdfs_pkg::REQ_UP + {1'b0, d};
   endfunction

   function automatic logic [1:0] reverse_dir(logic [1:0] d);
      return d ^ 2'b01;
   endfunction

   function automatic mdfs_pkg::result_type make_word(logic [2:0] r, logic [1:0] d, logic l);
      mdfs_pkg::result_type w;
      w.req  = r;
      w.dir  = d;
      w.last = l;
      return w;
   endfunction

   // next direction at this cell, or back off one level when all four are done
   function automatic mdfs_pkg::result_type try_next(int d);
      logic [1:0] p;
      if (d < 4) begin
         phase     = mdfs_pkg::PH_TRY;
         phase_dir = 2'(d);
         return make_word(move_request(2'(d)), NO_DIR, 1'b0);
      end
      if (stack_depth == 0) begin
         phase = mdfs_pkg::PH_NOTFOUND;
         return make_word(mdfs_pkg::REQ_NOTFOUND, NO_DIR, 1'b1);
      end
      stack_depth--;
      p         = path_stack[stack_depth];
      pos_x     = pos_x - step_dx(p);
      pos_y     = pos_y - step_dy(p);
      phase     = mdfs_pkg::PH_UNDO;
      phase_dir = p;
      return make_word(move_request(reverse_dir(p)), NO_DIR, 1'b0);
   endfunction

   function automatic mdfs_pkg::result_type enter_cell(logic [1:0] d);
      int nx;
      int ny;
      nx = pos_x + step_dx(d);
      ny = pos_y + step_dy(d);
      if (nx < 0 || ny < 0 || nx >= SIDE || ny >= SIDE || visited.exists(ny * SIDE + nx) ||
          stack_depth >= DEPTH_CAP) begin
         phase     = mdfs_pkg::PH_UNDO;
         phase_dir = d;
         return make_word(move_request(reverse_dir(d)), NO_DIR, 1'b0);
      end
      pos_x = nx;
      pos_y = ny;
      visited[ny * SIDE + nx] = 1'b1;
      path_stack[stack_depth] = d;
      stack_depth++;
      phase = mdfs_pkg::PH_ASK;
      return make_word(mdfs_pkg::REQ_ASK, NO_DIR, 1'b0);
   endfunction

   function automatic mdfs_pkg::result_type dfs_step(bit start, bit ans);
      logic [1:0] d;
      bit         fin;
      if (start) begin
         visited.delete();
         stack_depth = 0;
         report_idx  = 0;
         pos_x       = int'(start_x_q);
         pos_y       = int'(start_y_q);
         if (pos_x >= SIDE || pos_y >= SIDE) begin
            phase = mdfs_pkg::PH_NOTFOUND;
            return make_word(mdfs_pkg::REQ_NOTFOUND, NO_DIR, 1'b1);
         end
         visited[pos_y * SIDE + pos_x] = 1'b1;
         phase = mdfs_pkg::PH_ASK;
         return make_word(mdfs_pkg::REQ_ASK, NO_DIR, 1'b0);
      end
      case (phase)
         mdfs_pkg::PH_ASK: begin
            if (!ans) return try_next(0);
            report_idx = 0;
            phase = stack_depth == 0 ? mdfs_pkg::PH_FOUND : mdfs_pkg::PH_REPORT;
            return make_word(mdfs_pkg::REQ_FOUND, NO_DIR, stack_depth == 0);
         end
         mdfs_pkg::PH_TRY: begin
            if (ans) return enter_cell(phase_dir);
            return try_next(int'(phase_dir) + 1);
         end
         mdfs_pkg::PH_UNDO: begin
            return try_next(int'(phase_dir) + 1);
         end
         mdfs_pkg::PH_REPORT: begin
            d   = path_stack[report_idx];
            fin = report_idx + 1 >= stack_depth;
            report_idx++;
            if (fin) phase = mdfs_pkg::PH_FOUND;
            return make_word(mdfs_pkg::REQ_PATH, d, fin);
         end
         mdfs_pkg::PH_FOUND: begin
            return make_word(mdfs_pkg::REQ_FOUND, NO_DIR, 1'b1);
         end
         default: begin
            return make_word(mdfs_pkg::REQ_NOTFOUND, NO_DIR, 1'b1);
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
      fail_count++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp_val);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start_x_q   = mdfs_pkg::START_X_RESET;
         start_y_q   = mdfs_pkg::START_Y_RESET;
         visited.delete();
         stack_depth = 0;
         pos_x       = int'(start_x_q);
         pos_y       = int'(start_y_q);
         report_idx  = 0;
         phase       = mdfs_pkg::PH_IDLE;
         phase_dir   = NO_DIR;
         pending_requests.delete();
         leftovers_done = 1'b0;
         fail_count  = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == mdfs_pkg::CSR_START_X) start_x_q = csr_pwdata[7:0];
               else start_y_q = csr_pwdata[7:0];
            end else begin
               reg_value = csr_paddr[2] == mdfs_pkg::CSR_START_X ? start_x_q : start_y_q;
               if (csr_prdata[7:0] !== reg_value)
                  report_mismatch("register readback", 32'(csr_prdata[7:0]), 32'(reg_value));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_requests.size() == 0) begin
               report_mismatch("unexpected word, request", 32'(rsp_tdata[2:0]), 32'bx);
            end else begin
               want = pending_requests.pop_front();
               if (rsp_tdata[2:0] !== want.req)
                  report_mismatch("request", 32'(rsp_tdata[2:0]), 32'(want.req));
               if (rsp_tdata[4:3] !== want.dir)
                  report_mismatch("path direction", 32'(rsp_tdata[4:3]), 32'(want.dir));
               if (rsp_tlast !== want.last)
                  report_mismatch("last flag", 32'(rsp_tlast), 32'(want.last));
            end
         end
         if (req_tvalid && req_tready)
            pending_requests.push_back(dfs_step(req_tuser, req_tdata[0]));
         if (end_of_test && !leftovers_done) begin
            leftovers_done = 1'b1;
            while (pending_requests.size() > 0) begin
               want = pending_requests.pop_front();
               report_mismatch("word never delivered, request", 32'bx, 32'(want.req));
            end
         end
      end
   end

endmodule

>>> tb/tb_maze_dfs_explorer.sv
// Testbench top for the maze explorer: clock, reset, stimulus and verdict.
module tb_maze_dfs_explorer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD_TARGET  = 1530;
   localparam int CALM_FROM    = 1390;
   localparam int STALL_LIMIT  = 262144;
   localparam int SETTLE       = 4;
   localparam int DRAIN_CYCLES = 16;
   localparam logic [2:0] ADDR_START_X = {mdfs_pkg::CSR_START_X, 2'b00};
   localparam logic [2:0] ADDR_START_Y = {mdfs_pkg::CSR_START_Y, 2'b00};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        end_of_test;
   int          errors;

   int          sent_words;
   int          seen_words = 0;
   int          searches;
   int          path_steps = 0;
   int          found_words = 0;
   int          lost_words = 0;
   logic [2:0]  last_request = mdfs_pkg::REQ_NOTFOUND;
   logic        last_flag = 1'b1;
   bit          calm;
   int          rsp_stall = 0;
   int          quiet_cycles = 0;

   maze_dfs_explorer dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   maze_dfs_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready),
      .end_of_test(end_of_test), .fail_count(errors)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(negedge clock) begin
      if (calm) begin
         rsp_tready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall  <= int'($urandom_range(1, 4)) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_words   <= seen_words + 1;
         last_request <= rsp_tdata[2:0];
         last_flag    <= rsp_tlast;
         if (rsp_tdata[2:0] == mdfs_pkg::REQ_PATH) path_steps <= path_steps + 1;
         if (rsp_tdata[2:0] == mdfs_pkg::REQ_FOUND) found_words <= found_words + 1;
         if (rsp_tdata[2:0] == mdfs_pkg::REQ_NOTFOUND) lost_words <= lost_words + 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", quiet_cycles);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(bit start, bit ans);
      req_tuser  <= start;
      req_tdata  <= {7'b0, ans};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sent_words++;
      if (start) searches++;
      @(negedge clock);
   endtask

   task automatic drive_word(bit start, bit ans);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      send_word(start, ans);
   endtask

   task automatic await_reply();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (seen_words != sent_words);
   endtask

   task automatic csr_access(bit wr, logic [2:0] addr, logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= {24'b0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_start(logic [7:0] x, logic [7:0] y);
      await_reply();
      repeat (SETTLE) @(negedge clock);
      csr_access(1'b1, ADDR_START_X, x);
      csr_access(1'b0, ADDR_START_X, 8'h00);
      csr_access(1'b1, ADDR_START_Y, y);
      csr_access(1'b0, ADDR_START_Y, 8'h00);
   endtask

   initial begin
      int  cap;
      int  open_pct;
      int  tail;
      bit  ans;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      req_tuser   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      end_of_test = 1'b0;
      sent_words  = 0;
      searches    = 0;
      calm        = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // idle before any search, then a corner start with a short path
      drive_word(1'b0, 1'b0); drive_word(1'b0, 1'b1);
      set_start(8'd0, 8'd0);
      drive_word(1'b1, 1'b1); drive_word(1'b0, 1'b0); drive_word(1'b0, 1'b1);
      drive_word(1'b0, 1'b0); drive_word(1'b0, 1'b0); drive_word(1'b0, 1'b1);
      drive_word(1'b0, 1'b1); drive_word(1'b0, 1'b1); drive_word(1'b0, 1'b0);
      drive_word(1'b0, 1'b1); drive_word(1'b0, 1'b1); drive_word(1'b0, 1'b1);
      drive_word(1'b0, 1'b0); drive_word(1'b0, 1'b1); drive_word(1'b1, 1'b0);
      drive_word(1'b0, 1'b1);
      // far corner, every branch fails
      set_start(8'd255, 8'd255);
      drive_word(1'b1, 1'b0); drive_word(1'b0, 1'b0); drive_word(1'b0, 1'b1);
      drive_word(1'b0, 1'b1); drive_word(1'b0, 1'b0); drive_word(1'b0, 1'b0);
      drive_word(1'b0, 1'b0); drive_word(1'b0, 1'b1);

      while (sent_words < WORD_TARGET) begin
         if (sent_words >= CALM_FROM) calm = 1'b1;
         else calm = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 5))
               0:       set_start(8'd0, 8'd0);
               1:       set_start(8'd255, 8'd255);
               2:       set_start(8'd0, 8'd255);
               3:       set_start(8'd255, 8'd0);
               4:       set_start(mdfs_pkg::START_X_RESET, mdfs_pkg::START_Y_RESET);
               default: set_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
         end
         case ($urandom_range(0, 2))
            0:       open_pct = 15;
            1:       open_pct = 55;
            default: open_pct = 85;
         endcase
         cap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(10, 70);
         drive_word(1'b1, 1'($urandom_range(0, 1)));
         if ($urandom_range(0, 5) == 0) begin
            repeat (cap) drive_word($urandom_range(0, 29) == 0, 1'($urandom_range(0, 1)));
         end else begin
            tail = 0;
            for (int n = 0; n < cap; n++) begin
               await_reply();
               if (last_flag && (last_request == mdfs_pkg::REQ_FOUND ||
                                 last_request == mdfs_pkg::REQ_NOTFOUND))
                  tail++;
               if (tail > 2) break;
               case (last_request)
                  mdfs_pkg::REQ_ASK:
                     ans = ($urandom_range(0, 24) == 0);
                  mdfs_pkg::REQ_UP, mdfs_pkg::REQ_DOWN, mdfs_pkg::REQ_LEFT, mdfs_pkg::REQ_RIGHT:
                     ans = ($urandom_range(0, 99) < open_pct);
                  default:
                     ans = 1'($urandom_range(0, 1));
               endcase
               drive_word(1'b0, ans);
            end
         end
      end

      calm = 1'b1;
      await_reply();
      repeat (DRAIN_CYCLES) @(negedge clock);
      end_of_test <= 1'b1;
      repeat (2) @(negedge clock);
      $display("ran %0d words over %0d searches from several start cells", sent_words, searches);
      $display("seen %0d path steps, %0d found and %0d not-found words",
               path_steps, found_words, lost_words);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
